// ===== hdl/hob_pkg.sv =====
// ----------------------------------------------------------------------------
// hob_pkg
// Shared types, field widths, register codes and the palette of the heatmap
// overlay blender.
// ----------------------------------------------------------------------------
package hob_pkg;

	// default sizes
	localparam int PART_COUNT_DEF = 18;
	localparam int MAP_MAX_W_DEF  = 64;
	localparam int MAP_MAX_H_DEF  = 64;
	localparam int IMG_MAX_DEF    = 4096;

	// field widths
	localparam int PART_W  = 5;
	localparam int MAPC_W  = 6;
	localparam int HEAT_W  = 9;
	localparam int PIX_W   = 12;
	localparam int COLOR_W = 8;
	localparam int IMG_W   = 13;
	localparam int CELL_W  = 7;
	localparam int PROD_W  = 16;
	localparam int OVL_W   = 17;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PART       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd5;

	localparam logic [IMG_W-1:0]  RST_IMG_WIDTH  = 13'd640;
	localparam logic [IMG_W-1:0]  RST_IMG_HEIGHT = 13'd480;
	localparam logic [CELL_W-1:0] RST_MAP_WIDTH  = 7'd64;
	localparam logic [CELL_W-1:0] RST_MAP_HEIGHT = 7'd64;

	// opcodes and modes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_PIXEL   = 1'b1;
	localparam logic MODE_JET   = 1'b0;
	localparam logic MODE_ADDPL = 1'b1;

	// arithmetic constants
	localparam logic [HEAT_W-1:0] HEAT_ONE    = 9'd256;
	localparam logic [PROD_W-1:0] SUM_MAX     = 16'd65280;
	localparam int                BLEND_IN_W  = 77 * 256;
	localparam int                BLEND_OV_W  = 179;
	localparam int                BLEND_ROUND = 32768;
	localparam int                PAL_SIZE    = 19;

	typedef struct packed {
		logic               opcode;
		logic [PART_W-1:0]  map_part;
		logic [MAPC_W-1:0]  map_x;
		logic [MAPC_W-1:0]  map_y;
		logic [HEAT_W-1:0]  heat_value;
		logic [PIX_W-1:0]   pix_x;
		logic [PIX_W-1:0]   pix_y;
		logic [COLOR_W-1:0] blue_in;
		logic [COLOR_W-1:0] green_in;
		logic [COLOR_W-1:0] red_in;
	} item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] blue_out;
		logic [COLOR_W-1:0] green_out;
		logic [COLOR_W-1:0] red_out;
	} result_t;

	// palette entry as {red, green, blue}
	function automatic logic [23:0] pal_color(input logic [4:0] idx);
		logic [23:0] c;
		case (idx)
			5'd0:    c = {8'd255, 8'd0,   8'd0};
			5'd1:    c = {8'd255, 8'd85,  8'd0};
			5'd2:    c = {8'd255, 8'd170, 8'd0};
			5'd3:    c = {8'd255, 8'd255, 8'd0};
			5'd4:    c = {8'd170, 8'd255, 8'd0};
			5'd5:    c = {8'd85,  8'd255, 8'd0};
			5'd6:    c = {8'd0,   8'd255, 8'd0};
			5'd7:    c = {8'd0,   8'd255, 8'd85};
			5'd8:    c = {8'd0,   8'd255, 8'd170};
			5'd9:    c = {8'd0,   8'd255, 8'd255};
			5'd10:   c = {8'd0,   8'd170, 8'd255};
			5'd11:   c = {8'd0,   8'd85,  8'd255};
			5'd12:   c = {8'd0,   8'd0,   8'd255};
			5'd13:   c = {8'd85,  8'd0,   8'd255};
			5'd14:   c = {8'd170, 8'd0,   8'd255};
			5'd15:   c = {8'd255, 8'd0,   8'd255};
			5'd16:   c = {8'd255, 8'd0,   8'd170};
			5'd17:   c = {8'd255, 8'd0,   8'd85};
			5'd18:   c = {8'd85,  8'd85,  8'd170};
			default: c = 24'd0;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/hob_ram.sv =====
// ----------------------------------------------------------------------------
// hob_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hob_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/hob_cell.sv =====
// ----------------------------------------------------------------------------
// hob_cell
// Maps a pixel position to its nearest heatmap cell on both axes:
// floor(((2p+1)*cells - size) / (2*size)), one quotient bit per stage.
// ----------------------------------------------------------------------------
module hob_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  hob_pkg::item_t              in_word,
	input  logic [hob_pkg::IMG_W-1:0]   img_w,
	input  logic [hob_pkg::IMG_W-1:0]   img_h,
	input  logic [hob_pkg::CELL_W-1:0]  map_w,
	input  logic [hob_pkg::CELL_W-1:0]  map_h,
	output logic                        out_vld,
	output hob_pkg::item_t              out_word,
	output logic [hob_pkg::CELL_W-1:0]  cell_x,
	output logic [hob_pkg::CELL_W-1:0]  cell_y,
	output logic                        off_x,
	output logic                        off_y
);

	import hob_pkg::*;

	localparam int NW    = PIX_W + 1 + CELL_W;
	localparam int CW    = IMG_W + 1 + CELL_W;
	localparam int STEPS = CELL_W;

	logic [PIX_W-1:0]  pos  [2];
	logic [IMG_W-1:0]  ext  [2];
	logic [CELL_W-1:0] cells[2];

	logic [NW-1:0] prod_c [2];
	logic [NW-1:0] num_c  [2];
	logic          bad_c  [2];
	logic          ovf_c  [2];

	logic          ge_c  [1:STEPS][2];
	logic [NW-1:0] rem_c [1:STEPS-1][2];
	logic [CELL_W-1:0] q_c [1:STEPS][2];

	logic          vld_s1;
	item_t         word_s1;
	logic [NW-1:0] num_s1 [2];
	logic          bad_s1 [2];

	// division stages
	logic [STEPS:0]    vld_s;
	item_t             word_s [0:STEPS];
	logic [NW-1:0]     rem_s  [0:STEPS-1][2];
	logic [CELL_W-1:0] q_s    [0:STEPS][2];
	logic              bad_s  [0:STEPS][2];

	assign pos[0]   = in_word.pix_x;
	assign pos[1]   = in_word.pix_y;
	assign ext[0]   = img_w;
	assign ext[1]   = img_h;
	assign cells[0] = map_w;
	assign cells[1] = map_h;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			prod_c[a] = NW'({pos[a], 1'b1}) * NW'(cells[a]);
			num_c[a]  = prod_c[a] - NW'(ext[a]);
			bad_c[a]  = (prod_c[a] < NW'(ext[a])) || (ext[a] == '0) || (cells[a] == '0);
			ovf_c[a]  = CW'(num_s1[a]) >= {ext[a], 1'b0, CELL_W'(0)};
		end
	end

	always_comb begin
		for (int k = 1; k <= STEPS; k++) begin
			for (int a = 0; a < 2; a++) begin
				ge_c[k][a] = CW'(rem_s[k-1][a]) >= (CW'({ext[a], 1'b0}) << (STEPS - k));
				q_c[k][a]  = q_s[k-1][a] |
					(ge_c[k][a] ? (CELL_W'(1) << (STEPS - k)) : CELL_W'(0));
			end
		end
		for (int k = 1; k < STEPS; k++) begin
			for (int a = 0; a < 2; a++) begin
				rem_c[k][a] = ge_c[k][a] ?
					NW'(CW'(rem_s[k-1][a]) - (CW'({ext[a], 1'b0}) << (STEPS - k))) :
					rem_s[k-1][a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s  <= '0;
		end else if (en) begin
			vld_s1   <= in_vld;
			vld_s[0] <= vld_s1;
			for (int k = 1; k <= STEPS; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1   <= in_word;
			word_s[0] <= word_s1;
			for (int a = 0; a < 2; a++) begin
				num_s1[a]   <= num_c[a];
				bad_s1[a]   <= bad_c[a];
				rem_s[0][a] <= num_s1[a];
				q_s[0][a]   <= '0;
				bad_s[0][a] <= bad_s1[a] | ovf_c[a];
			end
			for (int k = 1; k <= STEPS; k++) begin
				word_s[k] <= word_s[k-1];
				for (int a = 0; a < 2; a++) begin
					q_s[k][a]   <= q_c[k][a];
					bad_s[k][a] <= bad_s[k-1][a];
				end
			end
			for (int k = 1; k < STEPS; k++) begin
				for (int a = 0; a < 2; a++) begin
					rem_s[k][a] <= rem_c[k][a];
				end
			end
		end
	end

	assign out_vld  = vld_s[STEPS];
	assign out_word = word_s[STEPS];
	assign cell_x   = q_s[STEPS][0];
	assign cell_y   = q_s[STEPS][1];
	assign off_x    = bad_s[STEPS][0];
	assign off_y    = bad_s[STEPS][1];

endmodule

// ===== hdl/heatmap_overlay_blend_core.sv =====
// ----------------------------------------------------------------------------
// heatmap_overlay_blend_core
// Blends a per-part heatmap over an image stream, one word per clock when not
// stalled. Load words fill the heatmap store; pixel words leave one blended
// pixel each, and a new word may enter in every cycle that is not stalled. The
// depth is set by the cell mapping, a restoring divider with one quotient bit
// per stage for each axis, followed by the store read and a registered adder
// tree over the parts. The store is one RAM bank per part, all read in
// parallel for a pixel; a load writes at the same stage where pixels read, so
// a pixel always sees every load accepted before it. The store needs no
// clearing pass after reset; an entry must be loaded before it is shown. A
// stall on the result side holds the whole pipeline.
// ----------------------------------------------------------------------------
module heatmap_overlay_blend_core #(
	parameter int PART_COUNT = hob_pkg::PART_COUNT_DEF,
	parameter int MAP_MAX_W  = hob_pkg::MAP_MAX_W_DEF,
	parameter int MAP_MAX_H  = hob_pkg::MAP_MAX_H_DEF,
	parameter int IMG_MAX    = hob_pkg::IMG_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  hob_pkg::item_t                 item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output hob_pkg::result_t               result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hob_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hob_pkg::CFG_DATA_W-1:0] cfg_data
);

	import hob_pkg::*;

	localparam int DEPTH  = MAP_MAX_W * MAP_MAX_H;
	localparam int AW     = $clog2(DEPTH);
	localparam int PSW    = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;
	localparam int GROUPS = (PART_COUNT + 3) / 4;
	localparam int SUM_W  = PROD_W + $clog2(PART_COUNT) + 1;

	typedef struct packed {
		logic [COLOR_W-1:0] b;
		logic [COLOR_W-1:0] g;
		logic [COLOR_W-1:0] r;
	} color_t;

	function automatic logic [3*HEAT_W-1:0] jet(input logic [HEAT_W-1:0] h);
		logic [10:0] h4;
		logic [10:0] cb;
		logic [10:0] cg;
		logic [10:0] cr;
		h4 = {h, 2'b00};
		if (h < 9'd32) begin
			cb = 11'd128 + h4;
			cg = 11'd0;
			cr = 11'd0;
		end else if (h < 9'd96) begin
			cb = 11'd255;
			cg = h4 - 11'd128;
			cr = 11'd0;
		end else if (h < 9'd160) begin
			cb = 11'd640 - h4;
			cg = 11'd255;
			cr = h4 - 11'd384;
		end else if (h < 9'd224) begin
			cb = 11'd0;
			cg = 11'd896 - h4;
			cr = 11'd255;
		end else begin
			cb = 11'd0;
			cg = 11'd0;
			cr = 11'd1152 - h4;
		end
		return {cb[HEAT_W-1:0], cg[HEAT_W-1:0], cr[HEAT_W-1:0]};
	endfunction

	function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] pin,
		input logic [OVL_W-1:0] ovl);
		logic [24:0] acc;
		acc = {17'd0, pin} * 25'(BLEND_IN_W) + {8'd0, ovl} * 25'(BLEND_OV_W)
			+ 25'(BLEND_ROUND);
		return acc[24] ? 8'hFF : acc[23:16];
	endfunction

	logic en;

	// configuration
	logic               mode_q;
	logic [PART_W-1:0]  part_q;
	logic [IMG_W-1:0]   img_w_q;
	logic [IMG_W-1:0]   img_h_q;
	logic [CELL_W-1:0]  map_w_q;
	logic [CELL_W-1:0]  map_h_q;

	logic [IMG_W-1:0]   img_w_c;
	logic [IMG_W-1:0]   img_h_c;
	logic [CELL_W-1:0]  map_w_c;
	logic [CELL_W-1:0]  map_h_c;
	logic [PART_W-1:0]  part_c;
	logic [PSW-1:0]     part_idx;

	// cell mapping outputs
	logic              cv_vld;
	item_t             cv_word;
	logic [CELL_W-1:0] cv_x;
	logic [CELL_W-1:0] cv_y;
	logic              cv_off_x;
	logic              cv_off_y;

	logic          inside_c;
	logic [AW-1:0] pix_addr_c;
	logic [AW-1:0] load_addr_c;
	logic          load_ok_c;

	logic              vld_s10;
	logic              pix_s10;
	logic              inside_s10;
	logic [AW-1:0]     addr_s10;
	logic              load_ok_s10;
	logic [PART_W-1:0] lpart_s10;
	logic [HEAT_W-1:0] lheat_s10;
	color_t            color_s10;

	logic [PART_COUNT-1:0] wen_c;
	logic                  ren_c;

	logic              vld_s11;
	logic              inside_s11;
	color_t            color_s11;
	logic [HEAT_W-1:0] heat_s11 [PART_COUNT];

	logic [HEAT_W-1:0] hcl_c   [PART_COUNT];
	logic [PROD_W-1:0] prod_r_c[PART_COUNT];
	logic [PROD_W-1:0] prod_g_c[PART_COUNT];
	logic [PROD_W-1:0] prod_b_c[PART_COUNT];

	logic              vld_s12;
	color_t            color_s12;
	logic [HEAT_W-1:0] hsel_s12;
	logic [PROD_W-1:0] prod_r_s12[PART_COUNT];
	logic [PROD_W-1:0] prod_g_s12[PART_COUNT];
	logic [PROD_W-1:0] prod_b_s12[PART_COUNT];

	logic [SUM_W-1:0] grp_r_c[GROUPS];
	logic [SUM_W-1:0] grp_g_c[GROUPS];
	logic [SUM_W-1:0] grp_b_c[GROUPS];

	logic                vld_s13;
	color_t              color_s13;
	logic [3*HEAT_W-1:0] jet_s13;
	logic [SUM_W-1:0]    grp_r_s13[GROUPS];
	logic [SUM_W-1:0]    grp_g_s13[GROUPS];
	logic [SUM_W-1:0]    grp_b_s13[GROUPS];

	logic [SUM_W-1:0]  tot_r_c;
	logic [SUM_W-1:0]  tot_g_c;
	logic [SUM_W-1:0]  tot_b_c;
	logic [OVL_W-1:0]  ovl_r_c;
	logic [OVL_W-1:0]  ovl_g_c;
	logic [OVL_W-1:0]  ovl_b_c;

	logic             vld_s14;
	color_t           color_s14;
	logic [OVL_W-1:0] ovl_r_s14;
	logic [OVL_W-1:0] ovl_g_s14;
	logic [OVL_W-1:0] ovl_b_s14;

	logic    result_vld_q;
	result_t result_q;

	// handshake
	assign en           = !(result_vld_q && result_stall);
	assign item_stall   = !en;
	assign result_valid = result_vld_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_JET;
			part_q  <= '0;
			img_w_q <= RST_IMG_WIDTH;
			img_h_q <= RST_IMG_HEIGHT;
			map_w_q <= RST_MAP_WIDTH;
			map_h_q <= RST_MAP_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:       mode_q  <= cfg_data[0];
				REG_PART:       part_q  <= cfg_data[PART_W-1:0];
				REG_IMG_WIDTH:  img_w_q <= cfg_data[IMG_W-1:0];
				REG_IMG_HEIGHT: img_h_q <= cfg_data[IMG_W-1:0];
				REG_MAP_WIDTH:  map_w_q <= cfg_data[CELL_W-1:0];
				REG_MAP_HEIGHT: map_h_q <= cfg_data[CELL_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated sizes and part
	assign img_w_c  = (32'(img_w_q) > IMG_MAX) ? IMG_W'(IMG_MAX) : img_w_q;
	assign img_h_c  = (32'(img_h_q) > IMG_MAX) ? IMG_W'(IMG_MAX) : img_h_q;
	assign map_w_c  = (32'(map_w_q) > MAP_MAX_W) ? CELL_W'(MAP_MAX_W) : map_w_q;
	assign map_h_c  = (32'(map_h_q) > MAP_MAX_H) ? CELL_W'(MAP_MAX_H) : map_h_q;
	assign part_c   = (32'(part_q) >= PART_COUNT) ? PART_W'(PART_COUNT - 1) : part_q;
	assign part_idx = part_c[PSW-1:0];

	hob_cell u_cell (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (item_valid),
		.in_word  (item),
		.img_w    (img_w_c),
		.img_h    (img_h_c),
		.map_w    (map_w_c),
		.map_h    (map_h_c),
		.out_vld  (cv_vld),
		.out_word (cv_word),
		.cell_x   (cv_x),
		.cell_y   (cv_y),
		.off_x    (cv_off_x),
		.off_y    (cv_off_y)
	);

	// store address
	assign inside_c    = !cv_off_x && !cv_off_y && (cv_x < map_w_c) && (cv_y < map_h_c);
	assign pix_addr_c  = AW'(32'(cv_y) * MAP_MAX_W + 32'(cv_x));
	assign load_addr_c = AW'(32'(cv_word.map_y) * MAP_MAX_W + 32'(cv_word.map_x));
	assign load_ok_c   = (32'(cv_word.map_part) < PART_COUNT) &&
		(32'(cv_word.map_x) < MAP_MAX_W) && (32'(cv_word.map_y) < MAP_MAX_H);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			result_vld_q <= 1'b0;
		end else if (en) begin
			vld_s10 <= cv_vld;
			vld_s11 <= vld_s10 && pix_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			result_vld_q <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s10     <= (cv_word.opcode == OP_PIXEL);
			inside_s10  <= inside_c;
			addr_s10    <= (cv_word.opcode == OP_PIXEL) ? pix_addr_c : load_addr_c;
			load_ok_s10 <= load_ok_c;
			lpart_s10   <= cv_word.map_part;
			lheat_s10   <= cv_word.heat_value;
			color_s10   <= '{b: cv_word.blue_in, g: cv_word.green_in, r: cv_word.red_in};
		end
	end

	// one bank per part
	assign ren_c = en && vld_s10 && pix_s10;

	for (genvar g = 0; g < PART_COUNT; g++) begin : g_bank
		localparam int          PAL_IDX = g % PAL_SIZE;
		localparam logic [23:0] PAL_RGB = pal_color(5'(PAL_IDX));

		assign wen_c[g] = en && vld_s10 && !pix_s10 && load_ok_s10 &&
			(lpart_s10 == PART_W'(g));

		hob_ram #(
			.WIDTH (HEAT_W),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wen_c[g]),
			.waddr (addr_s10),
			.wdata (lheat_s10),
			.re    (ren_c),
			.raddr (addr_s10),
			.rdata (heat_s11[g])
		);

		always_comb begin
			hcl_c[g] = (heat_s11[g] > HEAT_ONE) ? HEAT_ONE : heat_s11[g];
			if (inside_s11 && (PART_W'(g) >= part_c)) begin
				prod_r_c[g] = {7'd0, hcl_c[g]} * {8'd0, PAL_RGB[23:16]};
				prod_g_c[g] = {7'd0, hcl_c[g]} * {8'd0, PAL_RGB[15:8]};
				prod_b_c[g] = {7'd0, hcl_c[g]} * {8'd0, PAL_RGB[7:0]};
			end else begin
				prod_r_c[g] = '0;
				prod_g_c[g] = '0;
				prod_b_c[g] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s11 <= inside_s10;
			color_s11  <= color_s10;
			color_s12  <= color_s11;
			hsel_s12   <= inside_s11 ? hcl_c[part_idx] : '0;
			for (int p = 0; p < PART_COUNT; p++) begin
				prod_r_s12[p] <= prod_r_c[p];
				prod_g_s12[p] <= prod_g_c[p];
				prod_b_s12[p] <= prod_b_c[p];
			end
		end
	end

	// partial sums, four parts each
	always_comb begin
		for (int j = 0; j < GROUPS; j++) begin
			grp_r_c[j] = '0;
			grp_g_c[j] = '0;
			grp_b_c[j] = '0;
			for (int i = 0; i < 4; i++) begin
				if (4 * j + i < PART_COUNT) begin
					grp_r_c[j] = grp_r_c[j] + SUM_W'(prod_r_s12[4 * j + i]);
					grp_g_c[j] = grp_g_c[j] + SUM_W'(prod_g_s12[4 * j + i]);
					grp_b_c[j] = grp_b_c[j] + SUM_W'(prod_b_s12[4 * j + i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s13 <= color_s12;
			jet_s13   <= jet(hsel_s12);
			for (int j = 0; j < GROUPS; j++) begin
				grp_r_s13[j] <= grp_r_c[j];
				grp_g_s13[j] <= grp_g_c[j];
				grp_b_s13[j] <= grp_b_c[j];
			end
		end
	end

	// overlay color scaled by 256
	always_comb begin
		tot_r_c = '0;
		tot_g_c = '0;
		tot_b_c = '0;
		for (int j = 0; j < GROUPS; j++) begin
			tot_r_c = tot_r_c + grp_r_s13[j];
			tot_g_c = tot_g_c + grp_g_s13[j];
			tot_b_c = tot_b_c + grp_b_s13[j];
		end
		if (mode_q == MODE_ADDPL) begin
			ovl_r_c = (tot_r_c > SUM_W'(SUM_MAX)) ? OVL_W'(SUM_MAX) : OVL_W'(tot_r_c);
			ovl_g_c = (tot_g_c > SUM_W'(SUM_MAX)) ? OVL_W'(SUM_MAX) : OVL_W'(tot_g_c);
			ovl_b_c = (tot_b_c > SUM_W'(SUM_MAX)) ? OVL_W'(SUM_MAX) : OVL_W'(tot_b_c);
		end else begin
			ovl_b_c = {jet_s13[3*HEAT_W-1:2*HEAT_W], 8'd0};
			ovl_g_c = {jet_s13[2*HEAT_W-1:HEAT_W], 8'd0};
			ovl_r_c = {jet_s13[HEAT_W-1:0], 8'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			color_s14 <= color_s13;
			ovl_r_s14 <= ovl_r_c;
			ovl_g_s14 <= ovl_g_c;
			ovl_b_s14 <= ovl_b_c;
			result_q.blue_out  <= blend(color_s14.b, ovl_b_s14);
			result_q.green_out <= blend(color_s14.g, ovl_g_s14);
			result_q.red_out   <= blend(color_s14.r, ovl_r_s14);
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams heatmap load words and pixel words through heatmap_overlay_blend_core
// under random gaps and result stalls, over a series of register settings that
// include the extremes, and checks every blended pixel against a predictor of
// the cell mapping, jet colormap, palette sum and alpha blend.
// ----------------------------------------------------------------------------
module testbench;
	import hob_pkg::*;

	localparam int NPART = PART_COUNT_DEF;
	localparam int MAPW = MAP_MAX_W_DEF;
	localparam int MAPH = MAP_MAX_H_DEF;
	localparam int IMGMAX = IMG_MAX_DEF;
	localparam int HEAT_CELLS = NPART * MAPH * MAPW;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int PIPE_DRAIN = 40;
	localparam int PHASES = 14;
	localparam int WORDS_PER_PHASE = 95;

	class overlay_scoreboard;
		logic [HEAT_W-1:0] heat_mem [HEAT_CELLS];
		bit loaded [HEAT_CELLS];
		int pal_r [PAL_SIZE];
		int pal_g [PAL_SIZE];
		int pal_b [PAL_SIZE];
		bit mode;
		int part_sel, img_w, img_h, map_w, map_h;
		result_t pixels_due [$];
		int errors;

		function new();
			pal_r = '{255, 255, 255, 255, 170, 85, 0, 0, 0, 0, 0, 0, 0, 85, 170, 255, 255, 255, 85};
			pal_g = '{0, 85, 170, 255, 255, 255, 255, 255, 255, 255, 170, 85, 0, 0, 0, 0, 0, 0, 85};
			pal_b = '{0, 0, 0, 0, 0, 0, 0, 85, 170, 255, 255, 255, 255, 255, 255, 255, 170, 85, 170};
			mode = MODE_JET;
			part_sel = 0;
			img_w = RST_IMG_WIDTH;
			img_h = RST_IMG_HEIGHT;
			map_w = RST_MAP_WIDTH;
			map_h = RST_MAP_HEIGHT;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_MODE: begin
					mode = data[0];
				end
				REG_PART: begin
					part_sel = data[PART_W-1:0];
				end
				REG_IMG_WIDTH: begin
					img_w = data[IMG_W-1:0];
				end
				REG_IMG_HEIGHT: begin
					img_h = data[IMG_W-1:0];
				end
				REG_MAP_WIDTH: begin
					map_w = data[CELL_W-1:0];
				end
				REG_MAP_HEIGHT: begin
					map_h = data[CELL_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		// nearest cell on one axis, 0 when the pixel falls off the map
		function bit axis_cell(int pos, int img, int cells, int lim, output int cell_idx);
			int im, mp;
			longint num;
			im = img > IMGMAX ? IMGMAX : img;
			mp = cells > lim ? lim : cells;
			cell_idx = 0;
			if (im == 0 || mp == 0)
				return 1'b0;
			num = longint'(2 * pos + 1) * mp - im;
			if (num < 0)
				return 1'b0;
			num = num / (2 * im);
			if (num >= mp)
				return 1'b0;
			cell_idx = int'(num);
			return 1'b1;
		endfunction

		function bit locate(item_t w, output int cx, output int cy);
			bit in_x, in_y;
			in_x = axis_cell(w.pix_x, img_w, map_w, MAPW, cx);
			in_y = axis_cell(w.pix_y, img_h, map_h, MAPH, cy);
			return in_x && in_y;
		endfunction

		function int first_part();
			return part_sel >= NPART ? NPART - 1 : part_sel;
		endfunction

		function int last_part();
			return mode == MODE_JET ? first_part() : NPART - 1;
		endfunction

		function int slot(int p, int cx, int cy);
			return (p * MAPH + cy) * MAPW + cx;
		endfunction

		function int heat_at(int p, int cx, int cy);
			int v;
			v = heat_mem[slot(p, cx, cy)];
			return v > HEAT_ONE ? HEAT_ONE : v;
		endfunction

		function int mix(int in, int c);
			int v;
			v = (BLEND_IN_W * in + BLEND_OV_W * c + BLEND_ROUND) >>> 16;
			return v > 255 ? 255 : v;
		endfunction

		function result_t overlay_pixel(item_t w);
			int cx, cy, h, cb, cg, cr, p;
			bit on_map;
			result_t r;
			on_map = locate(w, cx, cy);
			if (mode == MODE_JET) begin
				h = on_map ? heat_at(first_part(), cx, cy) : 0;
				if (h < 32) begin
					cb = 128 + 4 * h; cg = 0; cr = 0;
				end else if (h < 96) begin
					cb = 255; cg = 4 * h - 128; cr = 0;
				end else if (h < 160) begin
					cb = 640 - 4 * h; cg = 255; cr = 4 * h - 384;
				end else if (h < 224) begin
					cb = 0; cg = 896 - 4 * h; cr = 255;
				end else begin
					cb = 0; cg = 0; cr = 1152 - 4 * h;
				end
				cb = cb * 256; cg = cg * 256; cr = cr * 256;
			end else begin
				cb = 0; cg = 0; cr = 0;
				if (on_map) begin
					for (p = first_part(); p < NPART; p++) begin
						h = heat_at(p, cx, cy);
						cr += h * pal_r[p % PAL_SIZE];
						cg += h * pal_g[p % PAL_SIZE];
						cb += h * pal_b[p % PAL_SIZE];
					end
				end
				if (cb > SUM_MAX) cb = SUM_MAX;
				if (cg > SUM_MAX) cg = SUM_MAX;
				if (cr > SUM_MAX) cr = SUM_MAX;
			end
			r.blue_out = COLOR_W'(mix(w.blue_in, cb));
			r.green_out = COLOR_W'(mix(w.green_in, cg));
			r.red_out = COLOR_W'(mix(w.red_in, cr));
			return r;
		endfunction

		function void note_word(item_t w);
			int a;
			if (w.opcode == OP_LOAD) begin
				if (w.map_part < NPART) begin
					a = slot(w.map_part, w.map_x, w.map_y);
					heat_mem[a] = w.heat_value;
					loaded[a] = 1'b1;
				end
			end else begin
				pixels_due = {pixels_due, overlay_pixel(w)};
			end
		endfunction

		function void check_pixel(result_t got);
			result_t want;
			if (pixels_due.size() == 0) begin
				$error("result word with no pixel outstanding: %h", got);
				errors++;
				return;
			end
			want = pixels_due.pop_front();
			if (got.blue_out !== want.blue_out) begin
				$error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
				errors++;
			end
			if (got.green_out !== want.green_out) begin
				$error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
				errors++;
			end
			if (got.red_out !== want.red_out) begin
				$error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	overlay_scoreboard sb = new();
	int words_sent;
	int last_x, last_y;
	bit have_last;
	bit sender_steady;

	heatmap_overlay_blend_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 15) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	function automatic int quiet_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(100, 300);
		return $urandom_range(0, 12);
	endfunction

	initial begin : result_backpressure
		result_stall = 1'b0;
		forever begin
			repeat (quiet_len()) @(negedge clk);
			@(negedge clk) result_stall <= 1'b1;
			repeat (idle_len()) @(negedge clk);
			@(negedge clk) result_stall <= 1'b0;
		end
	end

	always @(posedge clk)
		if (result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_pixel(result);

	function automatic item_t random_word();
		item_t w;
		w.opcode = 1'($urandom_range(0, 1));
		w.map_part = PART_W'($urandom_range(0, 31));
		w.map_x = MAPC_W'($urandom_range(0, 63));
		w.map_y = MAPC_W'($urandom_range(0, 63));
		w.heat_value = HEAT_W'($urandom_range(0, 511));
		w.pix_x = PIX_W'($urandom_range(0, 4095));
		w.pix_y = PIX_W'($urandom_range(0, 4095));
		w.blue_in = COLOR_W'($urandom_range(0, 255));
		w.green_in = COLOR_W'($urandom_range(0, 255));
		w.red_in = COLOR_W'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic int pick_heat();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return HEAT_ONE;
		if (r == 2) return $urandom_range(257, 511);
		if (r < 5) return $urandom_range(0, 40);
		return $urandom_range(0, 256);
	endfunction

	function automatic int pick_pos(int img);
		int eff, r;
		eff = img > IMGMAX ? IMGMAX : img;
		r = $urandom_range(0, 9);
		if (eff == 0 || r == 0) return $urandom_range(0, 4095);
		if (r == 1) return $urandom_range(0, 1) ? eff - 1 : 0;
		return $urandom_range(0, eff - 1);
	endfunction

	function automatic int pick_img();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r < 3) return $urandom_range(4097, 8191);
		if (r < 6) return $urandom_range(65, 4096);
		return $urandom_range(1, 64);
	endfunction

	function automatic int pick_map();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r < 3) return $urandom_range(65, 127);
		if (r < 6) return $urandom_range(9, 64);
		return $urandom_range(1, 8);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] with_junk(int v, int bits);
		logic [CFG_DATA_W-1:0] keep, d;
		keep = (CFG_DATA_W'(1) << bits) - CFG_DATA_W'(1);
		d = CFG_DATA_W'(v) & keep;
		if ($urandom_range(0, 3) == 0)
			d = d | (CFG_DATA_W'($urandom) & ~keep);
		return d;
	endfunction

	task automatic send_word(input item_t w);
		int gap;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= w;
		do @(posedge clk); while (item_stall !== 1'b0);
		sb.note_word(w);
		if (w.opcode == OP_PIXEL || w.map_part < NPART)
			words_sent++;
		gap = sender_steady ? 0 : idle_len();
		if (gap > 0) begin
			@(negedge clk) item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic load_cell(input int p, input int x, input int y, input int heat);
		item_t w;
		w = random_word();
		w.opcode = OP_LOAD;
		w.map_part = PART_W'(p);
		w.map_x = MAPC_W'(x);
		w.map_y = MAPC_W'(y);
		w.heat_value = HEAT_W'(heat);
		send_word(w);
	endtask

	// cells a pixel reads get loaded first
	task automatic send_pixel(input item_t w);
		int cx, cy, p;
		if (sb.locate(w, cx, cy))
			for (p = sb.first_part(); p <= sb.last_part(); p++)
				if (!sb.loaded[sb.slot(p, cx, cy)])
					load_cell(p, cx, cy, pick_heat());
		send_word(w);
	endtask

	task automatic random_pixel();
		item_t w;
		w = random_word();
		w.opcode = OP_PIXEL;
		if (have_last && $urandom_range(0, 2) == 0) begin
			w.pix_x = PIX_W'(last_x);
			w.pix_y = PIX_W'(last_y);
		end else begin
			w.pix_x = PIX_W'(pick_pos(sb.img_w));
			w.pix_y = PIX_W'(pick_pos(sb.img_h));
		end
		last_x = w.pix_x;
		last_y = w.pix_y;
		have_last = 1'b1;
		send_pixel(w);
	endtask

	task automatic random_step();
		item_t w;
		int r, mw, mh;
		r = $urandom_range(0, 19);
		if (r < 2) begin
			w = random_word();
			w.opcode = OP_LOAD;
			send_word(w);
		end else if (r == 2) begin
			mw = (sb.map_w == 0 || sb.map_w > MAPW) ? MAPW : sb.map_w;
			mh = (sb.map_h == 0 || sb.map_h > MAPH) ? MAPH : sb.map_h;
			load_cell($urandom_range(0, NPART - 1), $urandom_range(0, mw - 1),
				$urandom_range(0, mh - 1), pick_heat());
		end else begin
			random_pixel();
		end
	endtask

	task automatic settle();
		@(negedge clk) item_valid <= 1'b0;
		while (sb.pixels_due.size() != 0) @(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_reg(idx, data);
	endtask

	task automatic apply_setting(input bit m, input int ps, input int iw, input int ih,
		input int mw, input int mh);
		settle();
		if ($urandom_range(0, 2) == 0)
			program_reg(REG_NONE, CFG_DATA_W'($urandom));
		program_reg(REG_MODE, with_junk(m, 1));
		program_reg(REG_PART, with_junk(ps, PART_W));
		program_reg(REG_IMG_WIDTH, with_junk(iw, IMG_W));
		program_reg(REG_IMG_HEIGHT, with_junk(ih, IMG_W));
		program_reg(REG_MAP_WIDTH, with_junk(mw, CELL_W));
		program_reg(REG_MAP_HEIGHT, with_junk(mh, CELL_W));
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		item_t w;
		int k;
		int heats [8];
		heats = '{0, 31, 32, 96, 160, 224, 256, 511};
		// reset settings, both corners fall off the map
		w = random_word();
		w.opcode = OP_PIXEL;
		w.pix_x = '0;
		w.pix_y = '0;
		w.blue_in = '0;
		w.green_in = '0;
		w.red_in = '0;
		send_word(w);
		w.pix_x = '1;
		w.pix_y = '1;
		w.blue_in = '1;
		w.green_in = '1;
		w.red_in = '1;
		send_word(w);
		// one cell, part select past the last part
		apply_setting(MODE_JET, 31, 1, 1, 1, 1);
		w = random_word();
		w.opcode = OP_LOAD;
		w.map_part = '1;
		send_word(w);
		for (k = 0; k < 8; k++) begin
			load_cell(NPART - 1, 0, 0, heats[k]);
			w = random_word();
			w.opcode = OP_PIXEL;
			w.pix_x = '0;
			w.pix_y = '0;
			w.blue_in = k[0] ? 8'd255 : 8'd0;
			w.red_in = ~w.blue_in;
			send_word(w);
		end
		w.pix_x = PIX_W'(1);
		send_word(w);
	endtask

	initial begin : stimulus
		int ph, start;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		words_sent = 0;
		have_last = 1'b0;
		sender_steady = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		run_directed();
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_setting(MODE_ADDPL, 0, 4096, 4096, 64, 64);
				1: apply_setting(MODE_JET, 31, 8191, 8191, 127, 127);
				2: apply_setting(MODE_ADDPL, 17, 1, 1, 1, 1);
				3: apply_setting(MODE_JET, 5, 0, 480, 8, 8);
				4: apply_setting(MODE_ADDPL, 0, 37, 23, 5, 0);
				5: apply_setting(MODE_JET, 0, 1, 1, 64, 64);
				default: apply_setting($urandom_range(0, 1),
					$urandom_range(0, 4) == 0 ? $urandom_range(18, 31) : $urandom_range(0, 17),
					pick_img(), pick_img(), pick_map(), pick_map());
			endcase
			have_last = 1'b0;
			sender_steady = ($urandom_range(0, 4) == 0);
			start = words_sent;
			while (words_sent - start < WORDS_PER_PHASE)
				random_step();
		end
		settle();
		if (sb.errors == 0)
			$display("** heatmap_overlay_blend_core: PASSED **");
		else
			$display("** heatmap_overlay_blend_core: FAILED **");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("** heatmap_overlay_blend_core: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/hob_pkg.sv
hdl/hob_ram.sv
hdl/hob_cell.sv
hdl/heatmap_overlay_blend_core.sv
dv/testbench.sv
